@@ hdl/ftoi_pkg.sv @@
// ----------------------------------------------------------------------------
// ftoi_pkg
// Shared types and constants for the float to integer truncation block.
// ----------------------------------------------------------------------------
package ftoi_pkg;

   localparam int OperandWidth = 64;
   localparam int ResultWidth  = 64;
   localparam int MantWidth    = 53;
   localparam int ExpWidth     = 13;

   localparam logic [1:0] TRAP_NONE     = 2'd0;
   localparam logic [1:0] TRAP_INVALID  = 2'd1;
   localparam logic [1:0] TRAP_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                 sign;
      logic                 is_nan;
      logic                 is_inf;
      logic signed [ExpWidth-1:0] exponent;
      logic [MantWidth-1:0] mantissa;
   } unpacked_type;

   typedef struct packed {
      logic dest_is_wide;
      logic signed_result;
      logic saturate;
   } mode_type;

endpackage

@@ hdl/float_to_int_truncate.sv @@
// ----------------------------------------------------------------------------
// float_to_int_truncate
// Converts binary32/binary64 to 32/64-bit integers toward zero, trapping
// or saturating on NaN and out-of-range values.
//
//   channel   ports                         direction
//   request   start, busy, req_*            in (busy out)
//   result    rsp_valid, rsp_*              out
//
// A request is registered into operand_ff, double_ff and mode_ff and is
// converted; its result is registered into result_ff and trap_ff and is
// shown on rsp_* with rsp_valid.
// busy is always low: a new request may enter every cycle.
// Reset clears the valid flags only. The receiver cannot stall.
// ----------------------------------------------------------------------------
module float_to_int_truncate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ftoi_pkg::OperandWidth-1:0] req_operand_bits,
   input  logic                              req_source_is_double,
   input  logic                              req_dest_is_wide,
   input  logic                              req_signed_result,
   input  logic                              req_saturate,
   output logic                              rsp_valid,
   output logic [ftoi_pkg::ResultWidth-1:0]  rsp_result_bits,
   output logic [1:0]                        rsp_trap_code
);
   import ftoi_pkg::*;

   logic                    req_valid_ff;
   logic                    req_valid_in;
   logic [OperandWidth-1:0] operand_ff;
   logic                    double_ff;
   mode_type                mode_ff;
   mode_type                mode_in;
   unpacked_type            fields;
   logic [ResultWidth-1:0]  result_in;
   logic [1:0]              trap_in;
   logic                    rsp_valid_ff;
   logic [ResultWidth-1:0]  result_ff;
   logic [1:0]              trap_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign mode_in      = '{dest_is_wide: req_dest_is_wide,
                           signed_result: req_signed_result,
                           saturate: req_saturate};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         operand_ff <= req_operand_bits;
         double_ff  <= req_source_is_double;
         mode_ff    <= mode_in;
      end
      if (req_valid_ff) begin
         result_ff <= result_in;
         trap_ff   <= trap_in;
      end
   end

   ftoi_unpack u_unpack (
      .operand_bits     (operand_ff),
      .source_is_double (double_ff),
      .fields           (fields)
   );

   ftoi_convert u_convert (
      .fields      (fields),
      .mode        (mode_ff),
      .result_bits (result_in),
      .trap_code   (trap_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = result_ff;
   assign rsp_trap_code   = trap_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("result missing two cycles after request");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_trap_code <= TRAP_OVERFLOW)
      else $error("illegal trap code");

   a_trap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trap_code != TRAP_NONE |-> rsp_result_bits == '0)
      else $error("trap with nonzero result");

endmodule

@@ hdl/ftoi_unpack.sv @@
// ----------------------------------------------------------------------------
// ftoi_unpack
// Splits a binary32 or binary64 pattern into sign, unbiased exponent,
// 53-bit significand and special-value flags.
// ----------------------------------------------------------------------------
module ftoi_unpack (
   input  logic [ftoi_pkg::OperandWidth-1:0] operand_bits,
   input  logic                              source_is_double,
   output ftoi_pkg::unpacked_type            fields
);
   import ftoi_pkg::*;

   logic [10:0] exp_d;
   logic [7:0]  exp_s;
   logic [51:0] frac_d;
   logic [22:0] frac_s;

   always_comb begin
      exp_d  = operand_bits[62:52];
      frac_d = operand_bits[51:0];
      exp_s  = operand_bits[30:23];
      frac_s = operand_bits[22:0];
      if (source_is_double) begin
         fields.sign     = operand_bits[63];
         fields.is_nan   = (exp_d == 11'h7FF) && (frac_d != '0);
         fields.is_inf   = (exp_d == 11'h7FF) && (frac_d == '0);
         fields.exponent = $signed({2'b00, exp_d}) - 13'sd1023;
         fields.mantissa = {(exp_d != '0), frac_d};
      end else begin
         fields.sign     = operand_bits[31];
         fields.is_nan   = (exp_s == 8'hFF) && (frac_s != '0);
         fields.is_inf   = (exp_s == 8'hFF) && (frac_s == '0);
         fields.exponent = $signed({5'b00000, exp_s}) - 13'sd127;
         fields.mantissa = {(exp_s != '0), frac_s, 29'b0};
      end
   end

endmodule

@@ hdl/ftoi_convert.sv @@
// ----------------------------------------------------------------------------
// ftoi_convert
// Truncates the unpacked value to an integer magnitude, checks the range
// of the selected conversion and picks the value, limit or trap code.
// ----------------------------------------------------------------------------
module ftoi_convert (
   input  ftoi_pkg::unpacked_type           fields,
   input  ftoi_pkg::mode_type               mode,
   output logic [ftoi_pkg::ResultWidth-1:0] result_bits,
   output logic [1:0]                       trap_code
);
   import ftoi_pkg::*;

   logic        big;
   logic [63:0] mag;
   logic [63:0] neg_mag;
   logic [63:0] half;
   logic        out_low;
   logic        out_high;
   logic [63:0] min_val;
   logic [63:0] max_val;
   logic [63:0] value;
   logic [5:0]  shamt;

   always_comb begin
      big   = fields.is_inf || (fields.exponent >= 13'sd64);
      mag   = '0;
      shamt = '0;
      if (big) begin
         mag = '0;
      end else if (fields.exponent >= 13'sd52) begin
         shamt = 6'(fields.exponent - 13'sd52);
         mag   = {11'b0, fields.mantissa} << shamt;
      end else if (fields.exponent >= 13'sd0) begin
         shamt = 6'(13'sd52 - fields.exponent);
         mag   = {11'b0, fields.mantissa} >> shamt;
      end
      neg_mag = (~mag) + 64'd1;
      half    = mode.dest_is_wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;

      if (mode.signed_result) begin
         out_low  = fields.sign && (big || (mag > half));
         out_high = !fields.sign && (big || (mag >= half));
         min_val  = mode.dest_is_wide ? 64'h8000_0000_0000_0000
                                      : 64'h0000_0000_8000_0000;
         max_val  = half - 64'd1;
      end else begin
         out_low  = fields.sign && (big || (mag != '0));
         out_high = !fields.sign &&
                    (big || (!mode.dest_is_wide && (mag[63:32] != '0)));
         min_val  = '0;
         max_val  = mode.dest_is_wide ? 64'hFFFF_FFFF_FFFF_FFFF
                                      : 64'h0000_0000_FFFF_FFFF;
      end

      if (fields.sign) begin
         value = mode.signed_result ? neg_mag : '0;
      end else begin
         value = mag;
      end
      if (!mode.dest_is_wide) begin
         value[63:32] = '0;
      end

      result_bits = '0;
      trap_code   = TRAP_NONE;
      if (fields.is_nan) begin
         trap_code = mode.saturate ? TRAP_NONE : TRAP_INVALID;
      end else if (out_low) begin
         if (mode.saturate) result_bits = min_val;
         else trap_code = TRAP_OVERFLOW;
      end else if (out_high) begin
         if (mode.saturate) result_bits = max_val;
         else trap_code = TRAP_OVERFLOW;
      end else begin
         result_bits = value;
      end
   end

endmodule
